[hdl/frlf_pkg.sv]
package frlf_pkg;

  localparam int unsigned NUM_POINTS_DEF = 5;

  // field and accumulator widths, exact for up to 64 points
  localparam int unsigned ADC_W   = 16;
  localparam int unsigned FORCE_W = 24;
  localparam int unsigned SLOPE_W = 48;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SX_W    = 22;
  localparam int unsigned SXX_W   = 38;
  localparam int unsigned SY_W    = 30;
  localparam int unsigned SXY_W   = 46;
  localparam int unsigned ACC_W   = 54;
  localparam int unsigned DEN_W   = 44;
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned SPLIT   = 23;
  localparam int unsigned FRAC_W  = 16;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ORDER    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_SINGULAR = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PT_XX,
    S_PT_XY,
    S_PT_ACC,
    S_DEN_A,
    S_DEN_B,
    S_DEN_C,
    S_DEN_D,
    S_NUM_A,
    S_NUM_B,
    S_NUM_C,
    S_NUM_D,
    S_DIV_START,
    S_DIV_WAIT,
    S_FIN
  } ctl_state_e;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_RUN,
    D_DONE
  } div_state_e;

  typedef enum logic [2:0] {
    MUL_XX,
    MUL_XY,
    MUL_N_XX_LO,
    MUL_N_XX_HI,
    MUL_SX_SX,
    MUL_N_XY_LO,
    MUL_N_XY_HI,
    MUL_SX_SY
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_ADD_HI,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     sxx_add;
    logic     sxy_add;
    logic     den_load;
    logic     div_start;
  } ctl_t;

endpackage

[hdl/frlf_mul.sv]
module frlf_mul (
  input  logic                                 clk_i,
  input  logic signed [frlf_pkg::MUL_W-1:0]    a_i,
  input  logic signed [frlf_pkg::MUL_W-1:0]    b_i,
  output logic signed [frlf_pkg::PROD_W-1:0]   p_o
);

  logic signed [frlf_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= frlf_pkg::PROD_W'(a_i) * frlf_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

[hdl/frlf_div.sv]
module frlf_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [frlf_pkg::ACC_W-1:0]   num_i,
  input  logic        [frlf_pkg::DEN_W-1:0]   den_i,
  output logic                                done_o,
  output logic        [frlf_pkg::SLOPE_W-1:0] quot_o
);

  localparam int unsigned MAG_W  = frlf_pkg::ACC_W - 1;
  localparam int unsigned QW     = frlf_pkg::SLOPE_W;
  localparam int unsigned QCNT_W = $clog2(QW);
  localparam int unsigned CMP_W  = MAG_W + QW - frlf_pkg::FRAC_W;
  localparam int unsigned HI_W   = MAG_W - (QW - frlf_pkg::FRAC_W);

  localparam logic [QW-1:0] POS_LIMIT = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIMIT = {1'b1, {(QW-1){1'b0}}};

  frlf_pkg::div_state_e state_q, state_d;

  logic                             neg_q;
  logic                             sat_q;
  logic [MAG_W-1:0]                 mag_q;
  logic [frlf_pkg::DEN_W-1:0]       den_q;
  logic [frlf_pkg::DEN_W-1:0]       rem_q;
  logic [QW-1:0]                    sh_q;
  logic [QW-1:0]                    q_q;
  logic [QCNT_W-1:0]                cnt_q;

  logic [frlf_pkg::DEN_W:0]         trial;
  logic                             fits;
  logic                             too_big;
  logic [QW-1:0]                    q_clamped;

  assign trial   = {rem_q, sh_q[QW-1]};
  assign fits    = trial >= {1'b0, den_q};
  // quotient would need more than QW bits
  assign too_big = CMP_W'(mag_q) >= CMP_W'({den_q, {(QW-frlf_pkg::FRAC_W){1'b0}}});

  always_comb begin
    state_d = state_q;
    case (state_q)
      frlf_pkg::D_IDLE:  if (start_i) state_d = frlf_pkg::D_CHECK;
      frlf_pkg::D_CHECK: state_d = too_big ? frlf_pkg::D_DONE : frlf_pkg::D_RUN;
      frlf_pkg::D_RUN:   if (cnt_q == '0) state_d = frlf_pkg::D_DONE;
      frlf_pkg::D_DONE:  state_d = frlf_pkg::D_IDLE;
      default:           state_d = frlf_pkg::D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frlf_pkg::D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      frlf_pkg::D_IDLE: begin
        if (start_i) begin
          neg_q <= num_i[frlf_pkg::ACC_W-1];
          mag_q <= num_i[frlf_pkg::ACC_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);
          den_q <= den_i;
        end
      end
      frlf_pkg::D_CHECK: begin
        sat_q <= too_big;
        rem_q <= frlf_pkg::DEN_W'(mag_q[MAG_W-1 -: HI_W]);
        sh_q  <= {mag_q[QW-frlf_pkg::FRAC_W-1:0], {frlf_pkg::FRAC_W{1'b0}}};
        q_q   <= '0;
        cnt_q <= QCNT_W'(QW - 1);
      end
      frlf_pkg::D_RUN: begin
        rem_q <= fits ? frlf_pkg::DEN_W'(trial - {1'b0, den_q})
                      : trial[frlf_pkg::DEN_W-1:0];
        sh_q  <= {sh_q[QW-2:0], 1'b0};
        q_q   <= {q_q[QW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (neg_q) begin
      q_clamped = (sat_q || q_q > NEG_LIMIT) ? NEG_LIMIT : q_q;
      quot_o    = QW'(-q_clamped);
    end else begin
      q_clamped = (sat_q || q_q[QW-1]) ? POS_LIMIT : q_q;
      quot_o    = q_clamped;
    end
  end

  assign done_o = (state_q == frlf_pkg::D_DONE);

endmodule

[hdl/force_ratio_line_fit.sv]
// force_ratio_line_fit: least-squares slope of force against feedback adc reading
// input channel: one calibration point per beat (adc_reading_i, force_reading_i),
// in_valid_i / in_ready_o; a reading below the previous kept one is replaced by
// the previous point and the run is flagged out of order
// output channel: one beat per run of NUM_POINTS points (slope_o, status_o),
// out_valid_o / out_ready_i; status 0 ok, 1 order corrected, 2 singular fit
// each point is accepted, multiplied (x*x and x*y on the one shared 32x32
// multiplier) and accumulated; in_ready_o is low meanwhile
// after the last point, the multiplier and accumulator build the denominator
// (S_DEN_A to S_DEN_D), then the numerator (S_NUM_A to S_NUM_D); the bit-serial
// divider then forms the 48 quotient bits between a setup and a finish step;
// a singular fit skips the divider
// the output register frees the engine: a new run starts while the result
// waits; if a second result is ready before the first is taken, the block
// holds it and stops taking points until out_ready_i rises
// reset clears all sums, the point count and the output valid
module force_ratio_line_fit #(
  parameter int unsigned NUM_POINTS = frlf_pkg::NUM_POINTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [frlf_pkg::ADC_W-1:0]     adc_reading_i,
  input  logic signed [frlf_pkg::FORCE_W-1:0]   force_reading_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [frlf_pkg::SLOPE_W-1:0]   slope_o,
  output logic        [frlf_pkg::STAT_W-1:0]    status_o
);

  localparam int unsigned MW = frlf_pkg::MUL_W;
  localparam int unsigned SP = frlf_pkg::SPLIT;

  frlf_pkg::ctl_state_e state_q, state_d;
  frlf_pkg::ctl_t       ctl;

  logic [frlf_pkg::CNT_W-1:0]            count_q;
  logic signed [frlf_pkg::ADC_W-1:0]     prev_adc_q;
  logic signed [frlf_pkg::FORCE_W-1:0]   prev_force_q;
  logic signed [frlf_pkg::SX_W-1:0]      sum_x_q;
  logic signed [frlf_pkg::SXX_W-1:0]     sum_xx_q;
  logic signed [frlf_pkg::SY_W-1:0]      sum_y_q;
  logic signed [frlf_pkg::SXY_W-1:0]     sum_xy_q;
  logic                                  order_q;
  logic signed [frlf_pkg::ACC_W-1:0]     acc_q;
  logic [frlf_pkg::DEN_W-1:0]            den_q;
  logic                                  den_zero_q;
  logic [frlf_pkg::SLOPE_W-1:0]          res_slope_q;
  logic [frlf_pkg::STAT_W-1:0]           res_status_q;
  logic                                  out_valid_q;
  logic [frlf_pkg::SLOPE_W-1:0]          out_slope_q;
  logic [frlf_pkg::STAT_W-1:0]           out_status_q;

  logic                                  in_fire;
  logic                                  swap;
  logic signed [frlf_pkg::ADC_W-1:0]     x_keep;
  logic signed [frlf_pkg::FORCE_W-1:0]   y_keep;
  logic                                  last_point;
  logic                                  out_free;
  logic                                  fin_load;
  logic signed [MW-1:0]                  mul_a, mul_b;
  logic signed [frlf_pkg::PROD_W-1:0]    prod;
  logic signed [MW-1:0]                  n_op;
  logic                                  div_done;
  logic [frlf_pkg::SLOPE_W-1:0]          div_quot;

  assign in_ready_o = (state_q == frlf_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign swap       = (count_q != '0) && (adc_reading_i < prev_adc_q);
  assign x_keep     = swap ? prev_adc_q : adc_reading_i;
  assign y_keep     = swap ? prev_force_q : force_reading_i;
  assign last_point = (count_q == frlf_pkg::CNT_W'(NUM_POINTS));
  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_load   = (state_q == frlf_pkg::S_FIN) && out_free;
  assign n_op       = MW'(NUM_POINTS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      frlf_pkg::S_IDLE:      if (in_valid_i) state_d = frlf_pkg::S_PT_XX;
      frlf_pkg::S_PT_XX:     state_d = frlf_pkg::S_PT_XY;
      frlf_pkg::S_PT_XY:     state_d = frlf_pkg::S_PT_ACC;
      frlf_pkg::S_PT_ACC:    state_d = last_point ? frlf_pkg::S_DEN_A : frlf_pkg::S_IDLE;
      frlf_pkg::S_DEN_A:     state_d = frlf_pkg::S_DEN_B;
      frlf_pkg::S_DEN_B:     state_d = frlf_pkg::S_DEN_C;
      frlf_pkg::S_DEN_C:     state_d = frlf_pkg::S_DEN_D;
      frlf_pkg::S_DEN_D:     state_d = frlf_pkg::S_NUM_A;
      frlf_pkg::S_NUM_A:     state_d = frlf_pkg::S_NUM_B;
      frlf_pkg::S_NUM_B:     state_d = frlf_pkg::S_NUM_C;
      frlf_pkg::S_NUM_C:     state_d = frlf_pkg::S_NUM_D;
      frlf_pkg::S_NUM_D:     state_d = frlf_pkg::S_DIV_START;
      frlf_pkg::S_DIV_START: state_d = den_zero_q ? frlf_pkg::S_FIN : frlf_pkg::S_DIV_WAIT;
      frlf_pkg::S_DIV_WAIT:  if (div_done) state_d = frlf_pkg::S_FIN;
      frlf_pkg::S_FIN:       if (out_free) state_d = frlf_pkg::S_IDLE;
      default:               state_d = frlf_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl = '{mul_sel: frlf_pkg::MUL_XX, acc_op: frlf_pkg::ACC_HOLD, sxx_add: 1'b0,
            sxy_add: 1'b0, den_load: 1'b0, div_start: 1'b0};
    case (state_q)
      frlf_pkg::S_PT_XX: ctl.mul_sel = frlf_pkg::MUL_XX;
      frlf_pkg::S_PT_XY: begin
        ctl.mul_sel = frlf_pkg::MUL_XY;
        ctl.sxx_add = 1'b1;
      end
      frlf_pkg::S_PT_ACC: ctl.sxy_add = 1'b1;
      frlf_pkg::S_DEN_A: begin
        ctl.mul_sel = frlf_pkg::MUL_N_XX_LO;
        ctl.acc_op  = frlf_pkg::ACC_CLEAR;
      end
      frlf_pkg::S_DEN_B: begin
        ctl.mul_sel = frlf_pkg::MUL_N_XX_HI;
        ctl.acc_op  = frlf_pkg::ACC_ADD;
      end
      frlf_pkg::S_DEN_C: begin
        ctl.mul_sel = frlf_pkg::MUL_SX_SX;
        ctl.acc_op  = frlf_pkg::ACC_ADD_HI;
      end
      frlf_pkg::S_DEN_D: ctl.acc_op = frlf_pkg::ACC_SUB;
      frlf_pkg::S_NUM_A: begin
        ctl.mul_sel  = frlf_pkg::MUL_N_XY_LO;
        ctl.acc_op   = frlf_pkg::ACC_CLEAR;
        ctl.den_load = 1'b1;
      end
      frlf_pkg::S_NUM_B: begin
        ctl.mul_sel = frlf_pkg::MUL_N_XY_HI;
        ctl.acc_op  = frlf_pkg::ACC_ADD;
      end
      frlf_pkg::S_NUM_C: begin
        ctl.mul_sel = frlf_pkg::MUL_SX_SY;
        ctl.acc_op  = frlf_pkg::ACC_ADD_HI;
      end
      frlf_pkg::S_NUM_D: ctl.acc_op = frlf_pkg::ACC_SUB;
      frlf_pkg::S_DIV_START: ctl.div_start = !den_zero_q;
      default: ;
    endcase
  end

  // operand select for the shared multiplier; wide sums go in two halves
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul_sel)
      frlf_pkg::MUL_XX: begin
        mul_a = MW'(prev_adc_q);
        mul_b = MW'(prev_adc_q);
      end
      frlf_pkg::MUL_XY: begin
        mul_a = MW'(prev_adc_q);
        mul_b = MW'(prev_force_q);
      end
      frlf_pkg::MUL_N_XX_LO: begin
        mul_a = n_op;
        mul_b = MW'({1'b0, sum_xx_q[SP-1:0]});
      end
      frlf_pkg::MUL_N_XX_HI: begin
        mul_a = n_op;
        mul_b = MW'(sum_xx_q[frlf_pkg::SXX_W-1:SP]);
        if (sum_xx_q[frlf_pkg::SXX_W-1]) mul_b = mul_b | ~MW'({(frlf_pkg::SXX_W-SP){1'b1}});
      end
      frlf_pkg::MUL_SX_SX: begin
        mul_a = MW'(sum_x_q);
        mul_b = MW'(sum_x_q);
      end
      frlf_pkg::MUL_N_XY_LO: begin
        mul_a = n_op;
        mul_b = MW'({1'b0, sum_xy_q[SP-1:0]});
      end
      frlf_pkg::MUL_N_XY_HI: begin
        mul_a = n_op;
        mul_b = MW'(sum_xy_q[frlf_pkg::SXY_W-1:SP]);
        if (sum_xy_q[frlf_pkg::SXY_W-1]) mul_b = mul_b | ~MW'({(frlf_pkg::SXY_W-SP){1'b1}});
      end
      frlf_pkg::MUL_SX_SY: begin
        mul_a = MW'(sum_x_q);
        mul_b = MW'(sum_y_q);
      end
      default: ;
    endcase
  end

  frlf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  frlf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .num_i   (acc_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= frlf_pkg::S_IDLE;
      count_q      <= '0;
      prev_adc_q   <= '0;
      prev_force_q <= '0;
      sum_x_q      <= '0;
      sum_xx_q     <= '0;
      sum_y_q      <= '0;
      sum_xy_q     <= '0;
      order_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        prev_adc_q   <= x_keep;
        prev_force_q <= y_keep;
        sum_x_q      <= sum_x_q + frlf_pkg::SX_W'(x_keep);
        sum_y_q      <= sum_y_q + frlf_pkg::SY_W'(y_keep);
        count_q      <= count_q + 1'b1;
        if (swap) order_q <= 1'b1;
      end
      if (ctl.sxx_add) sum_xx_q <= sum_xx_q + prod[frlf_pkg::SXX_W-1:0];
      if (ctl.sxy_add) sum_xy_q <= sum_xy_q + prod[frlf_pkg::SXY_W-1:0];
      if (fin_load) begin
        // run done: run registers back to their reset values, the result goes valid
        count_q      <= '0;
        prev_adc_q   <= '0;
        prev_force_q <= '0;
        sum_x_q      <= '0;
        sum_xx_q     <= '0;
        sum_y_q      <= '0;
        sum_xy_q     <= '0;
        order_q      <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl.acc_op)
      frlf_pkg::ACC_CLEAR:  acc_q <= '0;
      frlf_pkg::ACC_ADD:    acc_q <= acc_q + prod[frlf_pkg::ACC_W-1:0];
      frlf_pkg::ACC_ADD_HI: acc_q <= acc_q + {prod[frlf_pkg::ACC_W-SP-1:0], {SP{1'b0}}};
      frlf_pkg::ACC_SUB:    acc_q <= acc_q - prod[frlf_pkg::ACC_W-1:0];
      default: ;
    endcase
    if (ctl.den_load) begin
      den_q      <= acc_q[frlf_pkg::DEN_W-1:0];
      den_zero_q <= (acc_q == '0) || acc_q[frlf_pkg::ACC_W-1];
    end
    if (state_q == frlf_pkg::S_DIV_START && den_zero_q) begin
      res_slope_q  <= '0;
      res_status_q <= frlf_pkg::STATUS_SINGULAR;
    end else if (state_q == frlf_pkg::S_DIV_WAIT && div_done) begin
      res_slope_q  <= div_quot;
      res_status_q <= order_q ? frlf_pkg::STATUS_ORDER : frlf_pkg::STATUS_OK;
    end
    if (fin_load) begin
      out_slope_q  <= res_slope_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slope_o     = out_slope_q;
  assign status_o    = out_status_q;

endmodule

[hdl/frlf_checker.sv]
module frlf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [frlf_pkg::SLOPE_W-1:0]        slope_o,
  input logic [frlf_pkg::STAT_W-1:0]         status_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slope_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // each point keeps the engine busy for the following cycles
  a_point_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("point accepted while previous point still in the multiplier");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == frlf_pkg::STATUS_OK || status_o == frlf_pkg::STATUS_ORDER
                    || status_o == frlf_pkg::STATUS_SINGULAR)
    else $error("undefined status code");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == frlf_pkg::STATUS_SINGULAR |-> slope_o == '0)
    else $error("singular fit with nonzero slope");

endmodule

bind force_ratio_line_fit frlf_checker u_frlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .slope_o     (slope_o),
  .status_o    (status_o)
);
